// File: sv/mpid_pkg.sv
// package for the multichannel pid with clamped integral
// widths, register indexes and channel count; no dependencies
`default_nettype none

package mpid_pkg;

    // channel count and field widths
    localparam int NUM_CHANNELS = 4;
    localparam int CHANNEL_W    = 2;
    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 16;
    localparam int LIMIT_W      = 14;
    localparam int DRIVE_W      = 32;
    localparam int GAIN_SHIFT   = 8;

    // internal arithmetic widths
    localparam int ERR_W   = SAMPLE_W + 1;        // target - measured
    localparam int INTEG_W = LIMIT_W + 1;         // clamped integral, signed
    localparam int WIDE_W  = ERR_W + 1;           // integral + error, error delta
    localparam int SUM_W   = GAIN_W + WIDE_W + 2; // three products summed

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd10000;

    // channels at or above this count are answered with a zero drive
    localparam logic [CHANNEL_W:0] CHANNEL_COUNT = NUM_CHANNELS[CHANNEL_W:0];

endpackage

`default_nettype wire

// File: sv/multichannel_pid_clamped_integral_top.sv
// top level of the multichannel pid with clamped integral
// depends on mpid_pkg for widths, register indexes and channel count
`default_nettype none

// Positional PID for NUM_CHANNELS loops sharing one set of Q8.8 gains. Each request
// carries a channel, a measured and a target value and yields exactly one result
// carrying the channel and a 32-bit signed drive:
//   error    = target - measured
//   integral = clamp(integral + error, -integral_limit, +integral_limit)
//   drive    = (prop_gain*error + integ_gain*integral
//               + deriv_gain*(error - prev_error)) >>> 8   (floor)
// after which the error becomes the channel's prev_error. Rate: one request per
// cycle, sustained while results are taken without stall; the whole update,
// including the per-channel state read-modify-write, sits between the input
// register and the result register, so requests to the same channel in
// consecutive cycles see each other's state. A stalled result register holds the
// input register too, so the block needs at most two requests of buffering.
// Configuration writes take effect at the clock edge of the write and are meant
// for idle periods. State and registers come out of reset as zero, except
// integral_limit which resets to 10000. A channel at or above NUM_CHANNELS gives a
// zero drive and leaves all state untouched.
module multichannel_pid_clamped_integral_top
    import mpid_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    // configuration write port
    input  wire logic                         i_cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic        [CFG_DATA_W-1:0] i_cfg_data,

    // sample requests
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic        [CHANNEL_W-1:0]  i_channel,
    input  wire logic signed [SAMPLE_W-1:0]   i_measured,
    input  wire logic signed [SAMPLE_W-1:0]   i_target,

    // drive results
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic             [CHANNEL_W-1:0]  o_out_channel,
    output logic signed      [DRIVE_W-1:0]    o_drive
);

    // configuration registers
    logic signed [GAIN_W-1:0]  r_prop_gain;
    logic signed [GAIN_W-1:0]  r_integ_gain;
    logic signed [GAIN_W-1:0]  r_deriv_gain;
    logic        [LIMIT_W-1:0] r_integral_limit;

    // per-channel loop state
    logic signed [ERR_W-1:0]   r_prev_err [NUM_CHANNELS];
    logic signed [INTEG_W-1:0] r_integ    [NUM_CHANNELS];

    // input register
    logic                       r_in_valid;
    logic [CHANNEL_W-1:0]       r_channel;
    logic signed [SAMPLE_W-1:0] r_measured;
    logic signed [SAMPLE_W-1:0] r_target;

    // result register
    logic                       r_out_valid;
    logic [CHANNEL_W-1:0]       r_out_channel;
    logic signed [DRIVE_W-1:0]  r_drive;

    // datapath
    logic                       in_range;
    logic                       advance;
    logic signed [ERR_W-1:0]    err;
    logic signed [WIDE_W-1:0]   acc_raw;
    logic signed [WIDE_W-1:0]   lim_pos;
    logic signed [WIDE_W-1:0]   lim_neg;
    logic signed [INTEG_W-1:0]  acc_sat;
    logic signed [WIDE_W-1:0]   err_delta;
    logic signed [GAIN_W+ERR_W-1:0]   p_term;
    logic signed [GAIN_W+INTEG_W-1:0] i_term;
    logic signed [GAIN_W+WIDE_W-1:0]  d_term;
    logic signed [SUM_W-1:0]    sum;
    logic signed [DRIVE_W-1:0]  n_drive;

    // handshake: the stage moves when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign in_range = {1'b0, r_channel} < CHANNEL_COUNT;

    // error and clamped integral
    always_comb begin
        err       = ERR_W'(r_target) - ERR_W'(r_measured);
        acc_raw   = WIDE_W'(r_integ[r_channel]) + WIDE_W'(err);
        lim_pos   = WIDE_W'({1'b0, r_integral_limit});
        lim_neg   = -lim_pos;
        err_delta = WIDE_W'(err) - WIDE_W'(r_prev_err[r_channel]);
        if (acc_raw > lim_pos) begin
            acc_sat = INTEG_W'(lim_pos);
        end else if (acc_raw < lim_neg) begin
            acc_sat = INTEG_W'(lim_neg);
        end else begin
            acc_sat = INTEG_W'(acc_raw);
        end
    end

    // three gain products, summed and scaled back from q8.8
    always_comb begin
        p_term = r_prop_gain * err;
        i_term = r_integ_gain * acc_sat;
        d_term = r_deriv_gain * err_delta;
        sum    = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
        // floor shift; the scaled sum is under 2^28 in magnitude,
        // so truncation to the 32-bit drive can never lose bits
        if (in_range) begin
            n_drive = DRIVE_W'(sum >>> GAIN_SHIFT);
        end else begin
            n_drive = '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain      <= '0;
            r_integ_gain     <= '0;
            r_deriv_gain     <= '0;
            r_integral_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROP_GAIN:      r_prop_gain      <= i_cfg_data;
                REG_INTEG_GAIN:     r_integ_gain     <= i_cfg_data;
                REG_DERIV_GAIN:     r_deriv_gain     <= i_cfg_data;
                REG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // per-channel state update, same edge as the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_prev_err[c] <= '0;
                r_integ[c]    <= '0;
            end
        end else if (advance && in_range) begin
            r_prev_err[r_channel] <= err;
            r_integ[r_channel]    <= acc_sat;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_channel  <= i_channel;
            r_measured <= i_measured;
            r_target   <= i_target;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_channel <= r_channel;
            r_drive       <= n_drive;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_drive       = r_drive;

    // a result only appears after the input register held a request
    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a staged request");

    // the stored error is the one just computed for that channel
    a_prev_err_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && in_range) |=> (r_prev_err[$past(r_channel)] == $past(err)))
        else $error("previous error not updated");

    // the stored integral is the clamped sum for that channel
    a_integ_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && in_range) |=> (r_integ[$past(r_channel)] == $past(acc_sat)))
        else $error("integral not updated");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !advance)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for multichannel_pid_clamped_integral_top
// keeps its own pid model per channel and compares every drive result with it
// depends on mpid_pkg and the top level
`default_nettype none

module testbench;
    import mpid_pkg::*;

    localparam int HALF_PERIOD   = 2;
    // idle slack after the last expected result is back
    localparam int SETTLE_CYCLES = 6;
    // worst case is far below this, even for ~2000 requests with random gaps and stalls
    localparam int RUN_LIMIT     = 2_000_000;

    localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN = -(longint'(1) <<< (DRIVE_W - 1));

    typedef struct packed {
        logic [CHANNEL_W-1:0] chan;
        logic [DRIVE_W-1:0]   drive;
    } t_drive_result;

    // dut signals; the inputs are all known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [CHANNEL_W-1:0]  i_channel   = '0;
    logic [SAMPLE_W-1:0]   i_measured  = '0;
    logic [SAMPLE_W-1:0]   i_target    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    logic [CHANNEL_W-1:0]  o_out_channel;
    logic [DRIVE_W-1:0]    o_drive;

    // shadow copy of the gain and limit registers
    logic signed [GAIN_W-1:0] kp_q88;
    logic signed [GAIN_W-1:0] ki_q88;
    logic signed [GAIN_W-1:0] kd_q88;
    logic [LIMIT_W-1:0]       integ_limit;

    // per-channel loop state as the block should hold it
    logic signed [ERR_W-1:0]   last_error [NUM_CHANNELS];
    logic signed [INTEG_W-1:0] integ_sum  [NUM_CHANNELS];

    t_drive_result        drive_expect_q [$];
    int                   mismatch_count = 0;
    bit                   gap_en         = 1'b0;
    bit                   stall_en       = 1'b0;
    logic [CHANNEL_W-1:0] last_chan      = '0;

    multichannel_pid_clamped_integral_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_channel     (i_channel),
        .i_measured    (i_measured),
        .i_target      (i_target),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_channel (o_out_channel),
        .o_drive       (o_drive)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // pid update for one accepted request; advances the loop state of its channel
    function automatic logic [DRIVE_W-1:0] pid_drive_step(
        input logic [CHANNEL_W-1:0]       ch,
        input logic signed [SAMPLE_W-1:0] meas,
        input logic signed [SAMPLE_W-1:0] targ
    );
        longint err;
        longint acc;
        longint lim;
        longint sum;
        longint drv;
        // channels past the loop count answer zero and touch nothing
        if ({1'b0, ch} >= CHANNEL_COUNT) begin
            return '0;
        end
        err = longint'(targ) - longint'(meas);
        lim = longint'(integ_limit);
        // integral saturates symmetrically at the configured bound
        acc = longint'(integ_sum[ch]) + err;
        if (acc > lim) begin
            acc = lim;
        end
        if (acc < -lim) begin
            acc = -lim;
        end
        sum = longint'(kp_q88) * err
            + longint'(ki_q88) * acc
            + longint'(kd_q88) * (err - longint'(last_error[ch]));
        // arithmetic shift on a signed value rounds toward minus infinity
        drv = sum >>> GAIN_SHIFT;
        if (drv > DRIVE_MAX) begin
            drv = DRIVE_MAX;
        end
        if (drv < DRIVE_MIN) begin
            drv = DRIVE_MIN;
        end
        integ_sum[ch]  = acc[INTEG_W-1:0];
        last_error[ch] = err[ERR_W-1:0];
        return drv[DRIVE_W-1:0];
    endfunction

    // one of the field extremes, or zero
    function automatic logic [SAMPLE_W-1:0] sample_extreme();
        case ($urandom_range(0, 2))
            0: return {1'b1, {(SAMPLE_W - 1){1'b0}}};
            1: return {1'b0, {(SAMPLE_W - 1){1'b1}}};
            default: return '0;
        endcase
    endfunction

    // predict on every accepted request, check on every accepted result
    always @(posedge i_clk) begin : score_proc
        t_drive_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want.chan  = i_channel;
                want.drive = pid_drive_step(i_channel, i_measured, i_target);
                drive_expect_q.push_back(want);
            end
            if (o_out_valid && i_out_ready) begin
                if (drive_expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got channel %0d drive %0d",
                             $time, o_out_channel, $signed(o_drive));
                    mismatch_count++;
                end else begin
                    want = drive_expect_q.pop_front();
                    if (o_out_channel !== want.chan) begin
                        $display("%0t: channel mismatch, expected %0d, actual %0d",
                                 $time, want.chan, o_out_channel);
                        mismatch_count++;
                    end
                    if (o_drive !== want.drive) begin
                        $display("%0t: drive mismatch on channel %0d, expected %0d, actual %0d",
                                 $time, want.chan, $signed(want.drive), $signed(o_drive));
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // result side back-pressure: random stall bursts with stall-free stretches between
    initial begin : sink_stall
        forever begin
            @(negedge i_clk);
            if (stall_en && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            if (stall_en) begin
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end
        end
    end

    // send one request; entered and left at a falling edge
    task automatic send_sample(input int ch, input int meas, input int targ);
        // optional gap before the request
        if (gap_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_channel  <= CHANNEL_W'(ch);
        i_measured <= SAMPLE_W'(meas);
        i_target   <= SAMPLE_W'(targ);
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // random request: mostly close to the set point so the integral builds up slowly
    task automatic send_random_sample();
        logic [CHANNEL_W-1:0] ch;
        logic [SAMPLE_W-1:0]  meas;
        logic [SAMPLE_W-1:0]  targ;
        int unsigned          pick;
        // half the time stay on the same loop to hit back-to-back state updates
        if ($urandom_range(0, 1) == 0) begin
            ch = last_chan;
        end else begin
            ch = CHANNEL_W'($urandom_range(0, 2 ** CHANNEL_W - 1));
        end
        meas = SAMPLE_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            targ = meas + SAMPLE_W'($urandom_range(0, 600)) - SAMPLE_W'(300);
        end else if (pick < 8) begin
            targ = SAMPLE_W'($urandom);
        end else begin
            meas = sample_extreme();
            targ = sample_extreme();
        end
        last_chan = ch;
        send_sample(int'(ch), int'(meas), int'(targ));
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (drive_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write all four registers on consecutive cycles, only while idle
    task automatic set_gains(input int kp, input int ki, input int kd, input int lim_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_PROP_GAIN;
        i_cfg_data <= CFG_DATA_W'(kp);
        @(negedge i_clk);
        i_cfg_idx  <= REG_INTEG_GAIN;
        i_cfg_data <= CFG_DATA_W'(ki);
        @(negedge i_clk);
        i_cfg_idx  <= REG_DERIV_GAIN;
        i_cfg_data <= CFG_DATA_W'(kd);
        @(negedge i_clk);
        i_cfg_idx  <= REG_INTEGRAL_LIMIT;
        i_cfg_data <= CFG_DATA_W'(lim_data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        kp_q88      = GAIN_W'(kp);
        ki_q88      = GAIN_W'(ki);
        kd_q88      = GAIN_W'(kd);
        // upper data bits fall outside the limit register
        integ_limit = LIMIT_W'(lim_data);
    endtask

    // reset values: zero gains give zero drive, but the integral still builds against 10000
    task automatic test_reset_state();
        send_sample(0, 0, 30000);
        send_sample(1, 32767, -32768);
        send_sample(2, 0, 0);
        wait_drained();
    endtask

    // hand-picked cases: unit gains, rounding, gain and field extremes, zero limit
    task automatic test_directed_cases();
        // unit gains, integral left over from the reset run becomes visible
        set_gains(256, 256, 256, int'(LIMIT_RESET));
        send_sample(0, 0, 0);
        send_sample(1, -32768, 32767);
        send_sample(1, 32767, -32768);
        wait_drained();

        // smallest proportional gain: floor rounding on either sign
        set_gains(1, 0, 0, int'(LIMIT_RESET));
        send_sample(2, 0, 1);
        send_sample(2, 1, 0);
        send_sample(2, 0, -255);
        wait_drained();

        // most negative and most positive gains, widest limit through masked data bits
        set_gains(-32768, 32767, -32768, 'hffff);
        send_sample(3, -32768, 32767);
        send_sample(3, 32767, -32768);
        send_sample(3, 0, 0);
        send_sample(3, 0, 0);
        wait_drained();

        // zero limit pins the integral; largest positive gains
        set_gains(32767, 32767, 32767, 'hc000);
        send_sample(0, 0, 5);
        send_sample(0, -5, 5);
        send_sample(0, 100, 100);
        wait_drained();
    endtask

    // several register settings, each followed by a random burst
    task automatic test_random_settings();
        int lim;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_gains(32767, 32767, 32767, 'hffff);
                1: set_gains(-32768, -32768, -32768, 'h0000);
                default: begin
                    // small limits now and then, so saturation comes often
                    lim = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 600)
                                                      : $urandom_range(0, 16383);
                    set_gains($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535),
                              ($urandom_range(0, 3) << LIMIT_W) | lim);
                end
            endcase
            repeat (230) send_random_sample();
            wait_drained();
        end
    endtask

    // no gaps and no stalls: one request per cycle at the full rate
    task automatic test_full_rate();
        gap_en   = 1'b0;
        stall_en = 1'b0;
        // let a stall burst still in progress run out first
        while (!i_out_ready) begin
            @(negedge i_clk);
        end
        set_gains($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
        repeat (300) send_random_sample();
        wait_drained();
    endtask

    initial begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            last_error[c] = '0;
            integ_sum[c]  = '0;
        end
        kp_q88      = '0;
        ki_q88      = '0;
        kd_q88      = '0;
        integ_limit = LIMIT_RESET;

        // synchronous reset held low at the start, then released
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        gap_en   = 1'b1;
        stall_en = 1'b1;

        test_reset_state();
        test_directed_cases();
        test_random_settings();
        test_full_rate();

        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin : watchdog
        #RUN_LIMIT;
        $display("%0t: timeout with %0d results outstanding", $time, drive_expect_q.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
